>>> hdl/ptc_pkg.sv
// Shared types and constants for the pressure and temperature compensation block.
package ptc_pkg;

	localparam int RawW       = 20;
	localparam int AddrW      = 5;
	localparam int DataW      = 64;
	localparam int NumW       = 64;
	localparam int DivisorW   = 31;
	localparam int DivStages  = NumW;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = QueuePtrW + 1;

	localparam int PressOffset = 1048576;
	localparam int FineOffset  = 128000;
	localparam int NumScale    = 3125;
	localparam int TempRound   = 128;
	localparam logic [63:0] WaBias = 64'h0000_8000_0000_0000;
	localparam logic [24:0] PressMax = 25'h1FF_FFFF;

	localparam logic [1:0] REG_CALIB_LOW  = 2'd0;
	localparam logic [1:0] REG_CALIB_MID  = 2'd1;
	localparam logic [1:0] REG_CALIB_HIGH = 2'd2;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} coef_t;

	typedef struct packed {
		logic [31:0]     fine;
		logic [15:0]     temp;
		logic [RawW-1:0] adc_p;
	} qentry_t;

	typedef struct packed {
		logic [15:0] temp;
		logic        neg;
		logic        zero;
	} div_side_t;

endpackage

>>> hdl/ptc_front.sv
// Input stage: accepts raw pairs and computes fine and centidegree temperature.
module ptc_front #(
	parameter int ADC_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ptc_pkg::coef_t            coef,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ptc_pkg::RawW-1:0]  raw_temperature,
	input  logic [ptc_pkg::RawW-1:0]  raw_pressure,
	output logic                      push,
	output ptc_pkg::qentry_t          push_data,
	input  logic                      full
);

	localparam logic [ptc_pkg::RawW-1:0] RawMask =
		{ptc_pkg::RawW{1'b1}} << (ptc_pkg::RawW - ADC_BITS);

	logic fe;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ptc_pkg::RawW-1:0] adc_t_s1;
	logic [ptc_pkg::RawW-1:0] adc_p_s1, adc_p_s2, adc_p_s3, adc_p_s4, adc_p_s5;
	logic [31:0] m1_s2, sqd_s2;
	logic [31:0] tv1_s3, m3_s3;
	logic [31:0] fine_s4, fine_s5;
	logic [15:0] temp_s5;

	logic signed [17:0] d1;
	logic signed [16:0] d2;
	logic signed [33:0] m1_full, sqd_full;
	logic signed [31:0] x3;
	logic signed [47:0] m3_full;
	logic [31:0] tcw;
	logic signed [31:0] tc;
	logic [15:0] tsat;

	// stall the whole front only when the last stage cannot hand off
	assign fe       = !v_s5 || !full;
	assign in_ready = fe;
	assign push     = v_s5 && !full;
	assign push_data = '{fine: fine_s5, temp: temp_s5, adc_p: adc_p_s5};

	assign d1 = $signed({1'b0, adc_t_s1[ptc_pkg::RawW-1:3]}) - $signed({1'b0, coef.t1, 1'b0});
	assign d2 = $signed({1'b0, adc_t_s1[ptc_pkg::RawW-1:4]}) - $signed({1'b0, coef.t1});
	assign m1_full  = d1 * $signed(coef.t2);
	assign sqd_full = d2 * d2;
	assign x3       = $signed(sqd_s2) >>> 12;
	assign m3_full  = x3 * $signed(coef.t3);
	assign tcw = fine_s4 + (fine_s4 << 2) + 32'(ptc_pkg::TempRound);
	assign tc  = $signed(tcw) >>> 8;

	always_comb begin
		if (tc > 32'sd32767) begin
			tsat = 16'h7FFF;
		end else if (tc < -32'sd32768) begin
			tsat = 16'h8000;
		end else begin
			tsat = tc[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (fe) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			adc_t_s1 <= raw_temperature & RawMask;
			adc_p_s1 <= raw_pressure & RawMask;
			m1_s2    <= m1_full[31:0];
			sqd_s2   <= sqd_full[31:0];
			adc_p_s2 <= adc_p_s1;
			tv1_s3   <= 32'($signed(m1_s2) >>> 11);
			m3_s3    <= m3_full[31:0];
			adc_p_s3 <= adc_p_s2;
			fine_s4  <= tv1_s3 + 32'($signed(m3_s3) >>> 14);
			adc_p_s4 <= adc_p_s3;
			fine_s5  <= fine_s4;
			temp_s5  <= tsat;
			adc_p_s5 <= adc_p_s4;
		end
	end

endmodule

>>> hdl/ptc_queue.sv
// Short queue between the temperature front and the pressure back.
module ptc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ptc_pkg::qentry_t push_data,
	output logic             full,
	input  logic             pop,
	output ptc_pkg::qentry_t pop_data,
	output logic             empty
);

	logic [ptc_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [ptc_pkg::QueueCntW-1:0] count_q;
	ptc_pkg::qentry_t mem_q [ptc_pkg::QueueDepth];

	assign full     = count_q == ptc_pkg::QueueCntW'(ptc_pkg::QueueDepth);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> hdl/ptc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
module ptc_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [ptc_pkg::NumW-1:0]      in_dividend,
	input  logic [ptc_pkg::DivisorW-1:0]  in_divisor,
	input  ptc_pkg::div_side_t            in_side,
	output logic                          out_valid,
	output logic [ptc_pkg::NumW-1:0]      out_quotient,
	output ptc_pkg::div_side_t            out_side
);

	localparam int N  = ptc_pkg::DivStages;
	localparam int W  = ptc_pkg::DivisorW;
	localparam int NW = ptc_pkg::NumW;

	logic               v_s    [N];
	logic [W-1:0]       rem_s  [N];
	logic [W-1:0]       dv_s   [N];
	logic [NW-1:0]      work_s [N];
	ptc_pkg::div_side_t side_s [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic               v_in;
		logic [W-1:0]       rem_in;
		logic [W-1:0]       dv_in;
		logic [NW-1:0]      work_in;
		ptc_pkg::div_side_t side_in;
		logic [W:0]         trial;
		logic               fits;

		if (i == 0) begin : g_head
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign dv_in   = in_divisor;
			assign work_in = in_dividend;
			assign side_in = in_side;
		end else begin : g_body
			assign v_in    = v_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign dv_in   = dv_s[i-1];
			assign work_in = work_s[i-1];
			assign side_in = side_s[i-1];
		end

		// shift in the next dividend bit and try to take off the divisor
		assign trial = {rem_in, work_in[NW-1]};
		assign fits  = trial >= {1'b0, dv_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= fits ? W'(trial - {1'b0, dv_in}) : W'(trial);
				dv_s[i]   <= dv_in;
				work_s[i] <= {work_in[NW-2:0], fits};
				side_s[i] <= side_in;
			end
		end
	end

	assign out_valid    = v_s[N-1];
	assign out_quotient = work_s[N-1];
	assign out_side     = side_s[N-1];

endmodule

>>> hdl/ptc_back.sv
// Pressure back end: 64-bit wrapping datapath, divider, saturation and result register.
module ptc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ptc_pkg::coef_t   coef,
	output logic             pop,
	input  ptc_pkg::qentry_t pop_data,
	input  logic             empty,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [15:0]      temperature_centi,
	output logic [24:0]      pressure_q24_8,
	output logic             calib_error
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, vo_q;

	logic [15:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic [15:0] temp_s10, temp_s11, temp_s12, temp_s13, temp_s14, temp_s15, temp_s16;
	logic zero_s10, zero_s11, zero_s12, zero_s13, zero_s14, zero_s15, zero_s16;
	logic [20:0] pd_s1, pd_s2, pd_s3, pd_s4, pd_s5;

	logic signed [33:0] v1_s1;
	logic [63:0] sq_s2;
	logic signed [49:0] v1p5_s2, v1p5_s3, v1p5_s4, v1p2_s2, v1p2_s3, v1p2_s4;
	logic signed [48:0] a6lo_s3, a3lo_s3;
	logic [31:0] a6hi_s3, a3hi_s3;
	logic [63:0] m6_s4, m3_s4;
	logic [63:0] v2_s5, wa_s5;
	logic [63:0] np_s6;
	logic [47:0] wlo_s6;
	logic [31:0] whi_s6;
	logic [30:0] w1_s7, w1_s8;
	logic [43:0] nlo_s7;
	logic [31:0] nhi_s7;
	logic [63:0] num_s8;
	logic [63:0] nmag_s9;
	logic [30:0] dmag_s9;
	ptc_pkg::div_side_t side_s9;

	logic [63:0] q_s10, q_s11, q_s12, q_s13, q_s14;
	logic [63:0] lolo_s11;
	logic [31:0] hl_s11;
	logic signed [48:0] a8lo_s11;
	logic [31:0] a8hi_s11;
	logic [63:0] sqh_s12;
	logic [63:0] a8_s12, a8_s13, a8_s14;
	logic signed [48:0] a9lo_s13;
	logic [31:0] a9hi_s13;
	logic [63:0] a9_s14;
	logic [63:0] sum_s15;
	logic [63:0] pr_s16;
	logic [15:0] temp_q;
	logic [24:0] press_q;
	logic        err_q;

	logic signed [33:0] v1_d;
	logic signed [67:0] sq_full;
	logic signed [49:0] v1p5_d, v1p2_d;
	logic signed [48:0] a6lo_d, a6hi_full, a3lo_d, a3hi_full;
	logic [47:0] wlo_d, whi_full;
	logic [63:0] wprod;
	logic [43:0] nlo_d, nhi_full;
	logic        dq_valid;
	logic [63:0] dq_mag;
	ptc_pkg::div_side_t dq_side;
	logic signed [63:0] ph;
	logic signed [51:0] hl_full;
	logic signed [48:0] a8lo_d, a8hi_full, a9lo_d, a9hi_full;
	logic [63:0] a8c, a9c;
	logic [24:0] psat;

	assign adv = !vo_q || out_ready;
	assign pop = adv && !empty;

	assign v1_d    = 34'($signed(pop_data.fine)) - 34'(ptc_pkg::FineOffset);
	assign sq_full = v1_s1 * v1_s1;
	assign v1p5_d  = v1_s1 * $signed(coef.p5);
	assign v1p2_d  = v1_s1 * $signed(coef.p2);
	assign a6lo_d    = $signed({1'b0, sq_s2[31:0]}) * $signed(coef.p6);
	assign a6hi_full = $signed({1'b0, sq_s2[63:32]}) * $signed(coef.p6);
	assign a3lo_d    = $signed({1'b0, sq_s2[31:0]}) * $signed(coef.p3);
	assign a3hi_full = $signed({1'b0, sq_s2[63:32]}) * $signed(coef.p3);
	assign wlo_d     = wa_s5[31:0] * coef.p1;
	assign whi_full  = wa_s5[63:32] * coef.p1;
	assign wprod     = {16'b0, wlo_s6} + {whi_s6, 32'b0};
	assign nlo_d     = np_s6[31:0] * 12'(ptc_pkg::NumScale);
	assign nhi_full  = np_s6[63:32] * 12'(ptc_pkg::NumScale);

	assign ph        = $signed(q_s10) >>> 13;
	assign hl_full   = $signed(ph[50:32]) * $signed({1'b0, ph[31:0]});
	assign a8lo_d    = $signed({1'b0, q_s10[31:0]}) * $signed(coef.p8);
	assign a8hi_full = $signed({1'b0, q_s10[63:32]}) * $signed(coef.p8);
	assign a8c       = 64'(a8lo_s11) + {a8hi_s11, 32'b0};
	assign a9lo_d    = $signed({1'b0, sqh_s12[31:0]}) * $signed(coef.p9);
	assign a9hi_full = $signed({1'b0, sqh_s12[63:32]}) * $signed(coef.p9);
	assign a9c       = 64'(a9lo_s13) + {a9hi_s13, 32'b0};

	always_comb begin
		if (pr_s16[63]) begin
			psat = '0;
		end else if (pr_s16 > 64'(ptc_pkg::PressMax)) begin
			psat = ptc_pkg::PressMax;
		end else begin
			psat = pr_s16[24:0];
		end
	end

	ptc_divider u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.in_valid     (v_s9),
		.in_dividend  (nmag_s9),
		.in_divisor   (dmag_s9),
		.in_side      (side_s9),
		.out_valid    (dq_valid),
		.out_quotient (dq_mag),
		.out_side     (dq_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			vo_q  <= 1'b0;
		end else if (adv) begin
			v_s1  <= !empty;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= dq_valid;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			vo_q  <= v_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// pre-divider: offset fine temperature, build numerator and divisor
			v1_s1   <= v1_d;
			pd_s1   <= 21'(ptc_pkg::PressOffset) - {1'b0, pop_data.adc_p};
			temp_s1 <= pop_data.temp;

			sq_s2   <= sq_full[63:0];
			v1p5_s2 <= v1p5_d;
			v1p2_s2 <= v1p2_d;
			pd_s2   <= pd_s1;
			temp_s2 <= temp_s1;

			a6lo_s3 <= a6lo_d;
			a6hi_s3 <= a6hi_full[31:0];
			a3lo_s3 <= a3lo_d;
			a3hi_s3 <= a3hi_full[31:0];
			v1p5_s3 <= v1p5_s2;
			v1p2_s3 <= v1p2_s2;
			pd_s3   <= pd_s2;
			temp_s3 <= temp_s2;

			m6_s4   <= 64'(a6lo_s3) + {a6hi_s3, 32'b0};
			m3_s4   <= 64'(a3lo_s3) + {a3hi_s3, 32'b0};
			v1p5_s4 <= v1p5_s3;
			v1p2_s4 <= v1p2_s3;
			pd_s4   <= pd_s3;
			temp_s4 <= temp_s3;

			v2_s5   <= m6_s4 + (64'(v1p5_s4) << 17) + (64'($signed(coef.p4)) << 35);
			wa_s5   <= 64'($signed(m3_s4) >>> 8) + (64'(v1p2_s4) << 12) + ptc_pkg::WaBias;
			pd_s5   <= pd_s4;
			temp_s5 <= temp_s4;

			np_s6   <= 64'({pd_s5, 31'b0}) - v2_s5;
			wlo_s6  <= wlo_d;
			whi_s6  <= whi_full[31:0];
			temp_s6 <= temp_s5;

			w1_s7   <= wprod[63:33];
			nlo_s7  <= nlo_d;
			nhi_s7  <= nhi_full[31:0];
			temp_s7 <= temp_s6;

			num_s8  <= {20'b0, nlo_s7} + {nhi_s7, 32'b0};
			w1_s8   <= w1_s7;
			temp_s8 <= temp_s7;

			nmag_s9 <= num_s8[63] ? 64'd0 - num_s8 : num_s8;
			dmag_s9 <= w1_s8[30] ? 31'd0 - w1_s8 : w1_s8;
			side_s9 <= '{temp: temp_s8, neg: num_s8[63] ^ w1_s8[30], zero: w1_s8 == '0};

			// after the divider: signed quotient and correction terms
			q_s10    <= dq_side.neg ? 64'd0 - dq_mag : dq_mag;
			temp_s10 <= dq_side.temp;
			zero_s10 <= dq_side.zero;

			lolo_s11 <= ph[31:0] * ph[31:0];
			hl_s11   <= hl_full[31:0];
			a8lo_s11 <= a8lo_d;
			a8hi_s11 <= a8hi_full[31:0];
			q_s11    <= q_s10;
			temp_s11 <= temp_s10;
			zero_s11 <= zero_s10;

			sqh_s12  <= lolo_s11 + {hl_s11[30:0], 33'b0};
			a8_s12   <= 64'($signed(a8c) >>> 19);
			q_s12    <= q_s11;
			temp_s12 <= temp_s11;
			zero_s12 <= zero_s11;

			a9lo_s13 <= a9lo_d;
			a9hi_s13 <= a9hi_full[31:0];
			a8_s13   <= a8_s12;
			q_s13    <= q_s12;
			temp_s13 <= temp_s12;
			zero_s13 <= zero_s12;

			a9_s14   <= 64'($signed(a9c) >>> 25);
			a8_s14   <= a8_s13;
			q_s14    <= q_s13;
			temp_s14 <= temp_s13;
			zero_s14 <= zero_s13;

			sum_s15  <= q_s14 + a9_s14 + a8_s14;
			temp_s15 <= temp_s14;
			zero_s15 <= zero_s14;

			pr_s16   <= 64'($signed(sum_s15) >>> 8) + (64'($signed(coef.p7)) << 4);
			temp_s16 <= temp_s15;
			zero_s16 <= zero_s15;

			temp_q  <= temp_s16;
			press_q <= zero_s16 ? '0 : psat;
			err_q   <= zero_s16;
		end
	end

	assign out_valid         = vo_q;
	assign temperature_centi = temp_q;
	assign pressure_q24_8    = press_q;
	assign calib_error       = err_q;

endmodule

>>> hdl/pressure_temp_compensation.sv
// Pressure and temperature compensation top level with calibration registers.
// Takes one raw temperature and pressure pair per clock while in_ready is high and returns
// one result per pair, in order. Five front stages compute the temperature, a four-entry
// queue follows, then nine stages build the pressure numerator and divisor, a 64-stage
// restoring divider produces one quotient bit per stage, and seven more stages plus the
// result register finish the pressure. The divider sets the latency; throughput stays one
// pair per cycle while out_ready stays high. The front and back stall separately, so input
// can keep flowing while a result waits. Calibration is three 64-bit registers at byte
// addresses 0, 8 and 16. The user must write them only while idle; no logic enforces it.
module pressure_temp_compensation #(
	parameter int ADC_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ptc_pkg::AddrW-1:0] paddr,
	input  logic [ptc_pkg::DataW-1:0] pwdata,
	output logic [ptc_pkg::DataW-1:0] prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ptc_pkg::RawW-1:0]  raw_temperature,
	input  logic [ptc_pkg::RawW-1:0]  raw_pressure,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [15:0]        temperature_centi,
	output logic [24:0]               pressure_q24_8,
	output logic                      calib_error
);

	logic [ptc_pkg::DataW-1:0] calib_low_q, calib_mid_q, calib_high_q;
	logic [1:0] reg_idx;
	ptc_pkg::coef_t coef;
	logic push, full, pop, empty;
	ptc_pkg::qentry_t push_data, pop_data;
	logic [15:0] temp_out;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_low_q  <= '0;
			calib_mid_q  <= '0;
			calib_high_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				ptc_pkg::REG_CALIB_LOW:  calib_low_q  <= pwdata;
				ptc_pkg::REG_CALIB_MID:  calib_mid_q  <= pwdata;
				ptc_pkg::REG_CALIB_HIGH: calib_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ptc_pkg::REG_CALIB_LOW:  prdata = calib_low_q;
			ptc_pkg::REG_CALIB_MID:  prdata = calib_mid_q;
			ptc_pkg::REG_CALIB_HIGH: prdata = calib_high_q;
			default:                 prdata = '0;
		endcase
	end

	assign coef = '{
		t1: calib_low_q[15:0],  t2: calib_low_q[31:16],
		t3: calib_low_q[47:32], p1: calib_low_q[63:48],
		p2: calib_mid_q[15:0],  p3: calib_mid_q[31:16],
		p4: calib_mid_q[47:32], p5: calib_mid_q[63:48],
		p6: calib_high_q[15:0],  p7: calib_high_q[31:16],
		p8: calib_high_q[47:32], p9: calib_high_q[63:48]
	};

	ptc_front #(
		.ADC_BITS (ADC_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.coef            (coef),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.push            (push),
		.push_data       (push_data),
		.full            (full)
	);

	ptc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	ptc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.coef              (coef),
		.pop               (pop),
		.pop_data          (pop_data),
		.empty             (empty),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temp_out),
		.pressure_q24_8    (pressure_q24_8),
		.calib_error       (calib_error)
	);

	assign temperature_centi = $signed(temp_out);

endmodule

>>> hdl/ptc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
module ptc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      psel,
	input logic                      penable,
	input logic                      pwrite,
	input logic [ptc_pkg::AddrW-1:0] paddr,
	input logic [ptc_pkg::DataW-1:0] pwdata,
	input logic [ptc_pkg::DataW-1:0] prdata,
	input logic                      pready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [15:0]        temperature_centi,
	input logic [24:0]               pressure_q24_8,
	input logic                      calib_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(temperature_centi) && $stable(pressure_q24_8)
			&& $stable(calib_error))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calib_error |-> pressure_q24_8 == '0)
		else $error("pressure not cleared on calibration error");

	a_reg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[4:3] == ptc_pkg::REG_CALIB_LOW
			|| paddr[4:3] == ptc_pkg::REG_CALIB_MID || paddr[4:3] == ptc_pkg::REG_CALIB_HIGH))
		##1 (psel && !pwrite && paddr[4:3] == $past(paddr[4:3]))
		|-> prdata == $past(pwdata) && pready)
		else $error("register readback mismatch");

endmodule

bind pressure_temp_compensation ptc_checker u_checker (.*);
